FILE: rtl/frd_pkg.sv
// Package: widths, reset values, register indexes and result type of the FSK frame demodulator.
package frd_pkg;

    localparam int TIME_WIDTH  = 32;
    localparam int FRAME_WIDTH = 64;
    localparam int CARD_WIDTH  = 24;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 10;

    localparam int PERIOD_W = 10;
    localparam int RUN_W    = 4;
    localparam int SYNC_W   = 8;
    localparam int HALF_W   = 7;

    localparam logic [PERIOD_W-1:0] MIN_PERIOD_RST     = PERIOD_W'(50);
    localparam logic [PERIOD_W-1:0] SHORT_LIMIT_RST    = PERIOD_W'(70);
    localparam logic [PERIOD_W-1:0] LONG_LIMIT_RST     = PERIOD_W'(100);
    localparam logic [RUN_W-1:0]    ZERO_RUN_RST       = RUN_W'(6);
    localparam logic [RUN_W-1:0]    ONE_RUN_RST        = RUN_W'(5);
    localparam logic [SYNC_W-1:0]   SYNC_RUN_RST       = SYNC_W'(15);
    localparam logic [HALF_W-1:0]   FRAME_HALFBITS_RST = HALF_W'(90);

    localparam logic [SYNC_W-1:0] LONG_COUNT_MAX = '1;
    localparam logic [HALF_W-1:0] HALF_COUNT_MAX = '1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_PERIOD     = 3'd0,
        CFG_SHORT_LIMIT    = 3'd1,
        CFG_LONG_LIMIT     = 3'd2,
        CFG_ZERO_RUN       = 3'd3,
        CFG_ONE_RUN        = 3'd4,
        CFG_SYNC_RUN       = 3'd5,
        CFG_FRAME_HALFBITS = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic                   frame_valid;
        logic [CARD_WIDTH-1:0]  card_number;
        logic [FRAME_WIDTH-1:0] raw_frame;
        logic                   sync_seen;
    } t_result;

endpackage

FILE: rtl/frd_if.sv
// Interfaces: edge input, result output and configuration write channels.
interface frd_in_if import frd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [TIME_WIDTH-1:0] edge_time;

    modport source (output valid, output edge_time, input ready);
    modport sink (input valid, input edge_time, output ready);
endinterface

interface frd_out_if import frd_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   frame_valid;
    logic [CARD_WIDTH-1:0]  card_number;
    logic [FRAME_WIDTH-1:0] raw_frame;
    logic                   sync_seen;

    modport source (output valid, output frame_valid, output card_number,
                    output raw_frame, output sync_seen, input ready);
    modport sink (input valid, input frame_valid, input card_number,
                  input raw_frame, input sync_seen, output ready);
endinterface

interface frd_cfg_if import frd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/fsk_rfid_frame_demodulator_core.sv
// Top level: FSK carrier edge classifier, Manchester decoder and frame register.
// Each edge transaction's result is registered into the output register, or into the skid entry while a result waits.
// Throughput: one edge per cycle while the skid entry is empty; the per-edge compare-and-update step is combinational.
// A two-entry output buffer keeps accepting edges while one result waits downstream.
// Reset (synchronous, active low) clears decoder state and loads register defaults.
module fsk_rfid_frame_demodulator_core import frd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    frd_cfg_if.sink   i_cfg,
    frd_in_if.sink    i_edge,
    frd_out_if.source o_result
);

    // Configuration registers
    logic [PERIOD_W-1:0] r_min_period, r_short_limit, r_long_limit;
    logic [RUN_W-1:0]    r_zero_run, r_one_run;
    logic [SYNC_W-1:0]   r_sync_run;
    logic [HALF_W-1:0]   r_frame_halfbits;

    // Decoder state
    logic [TIME_WIDTH-1:0]  r_last_edge;
    logic [RUN_W-1:0]       r_short_count, n_short_count;
    logic [SYNC_W-1:0]      r_long_count, n_long_count;
    logic [RUN_W-1:0]       r_long_phase, n_long_phase;
    logic [HALF_W-1:0]      r_half_count, n_half_count;
    logic                   r_first_half, n_first_half;
    logic [FRAME_WIDTH-1:0] r_frame_shift, n_frame_shift;

    // Output buffer
    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid, n_result;

    logic                  in_accept, out_pop, cfg_accept;
    logic [TIME_WIDTH-1:0] delta;
    logic                  above_min, is_short, is_long;
    logic                  half_put, half_bit, sync;
    logic [RUN_W-1:0]      short_inc, phase_inc;
    logic [SYNC_W-1:0]     long_inc;

    assign i_cfg.ready  = 1'b1;
    assign cfg_accept   = i_cfg.valid && i_cfg.ready;
    assign i_edge.ready = !r_skid_valid;
    assign in_accept    = i_edge.valid && i_edge.ready;
    assign out_pop      = r_out_valid && o_result.ready;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_period     <= MIN_PERIOD_RST;
            r_short_limit    <= SHORT_LIMIT_RST;
            r_long_limit     <= LONG_LIMIT_RST;
            r_zero_run       <= ZERO_RUN_RST;
            r_one_run        <= ONE_RUN_RST;
            r_sync_run       <= SYNC_RUN_RST;
            r_frame_halfbits <= FRAME_HALFBITS_RST;
        end else if (cfg_accept) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_MIN_PERIOD:     r_min_period     <= i_cfg.data;
                CFG_SHORT_LIMIT:    r_short_limit    <= i_cfg.data;
                CFG_LONG_LIMIT:     r_long_limit     <= i_cfg.data;
                CFG_ZERO_RUN:       r_zero_run       <= i_cfg.data[RUN_W-1:0];
                CFG_ONE_RUN:        r_one_run        <= i_cfg.data[RUN_W-1:0];
                CFG_SYNC_RUN:       r_sync_run       <= i_cfg.data[SYNC_W-1:0];
                CFG_FRAME_HALFBITS: r_frame_halfbits <= i_cfg.data[HALF_W-1:0];
                default: ;
            endcase
        end
    end

    // Classify the period since the previous edge
    assign delta     = i_edge.edge_time - r_last_edge;
    assign above_min = delta > TIME_WIDTH'(r_min_period);
    assign is_short  = above_min && (delta < TIME_WIDTH'(r_short_limit));
    assign is_long   = !is_short && above_min && (delta < TIME_WIDTH'(r_long_limit));
    assign short_inc = r_short_count + RUN_W'(1);
    assign phase_inc = r_long_phase + RUN_W'(1);
    assign long_inc  = r_long_count + SYNC_W'(1);

    // Count runs, form half-bits, Manchester decode and build the result
    always_comb begin
        n_short_count = '0;
        n_long_count  = '0;
        n_long_phase  = '0;
        half_put      = 1'b0;
        half_bit      = 1'b0;
        sync          = 1'b0;
        n_half_count  = r_half_count;
        n_first_half  = r_first_half;
        n_frame_shift = r_frame_shift;

        if (is_short) begin
            if (short_inc == r_zero_run) begin
                half_put = 1'b1;
            end else begin
                n_short_count = short_inc;
            end
        end else if (is_long) begin
            if (r_long_count != LONG_COUNT_MAX) begin
                n_long_count = long_inc;
                sync         = (long_inc == r_sync_run);
            end else begin
                n_long_count = r_long_count;
            end
            if (phase_inc == r_one_run) begin
                half_put = 1'b1;
                half_bit = 1'b1;
            end else begin
                n_long_phase = phase_inc;
            end
        end

        // Pair half-bits; a second half equal to the first is dropped
        if (half_put) begin
            if (r_half_count[0]) begin
                if (half_bit != r_first_half) begin
                    n_frame_shift = {r_frame_shift[FRAME_WIDTH-2:0], r_first_half};
                    if (r_half_count != HALF_COUNT_MAX) begin
                        n_half_count = r_half_count + HALF_W'(1);
                    end
                end
            end else begin
                n_first_half = half_bit;
                if (r_half_count != HALF_COUNT_MAX) begin
                    n_half_count = r_half_count + HALF_W'(1);
                end
            end
        end

        // Clear the frame on sync
        if (sync) begin
            n_half_count  = '0;
            n_frame_shift = '0;
        end

        n_result.frame_valid = (n_half_count == r_frame_halfbits);
        n_result.card_number = n_frame_shift[CARD_WIDTH:1];
        n_result.raw_frame   = n_frame_shift;
        n_result.sync_seen   = sync;
    end

    // Advance decoder state on each edge transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_edge   <= '0;
            r_short_count <= '0;
            r_long_count  <= '0;
            r_long_phase  <= '0;
            r_half_count  <= '0;
            r_first_half  <= 1'b0;
            r_frame_shift <= '0;
        end else if (in_accept) begin
            r_last_edge   <= i_edge.edge_time;
            r_short_count <= n_short_count;
            r_long_count  <= n_long_count;
            r_long_phase  <= n_long_phase;
            r_half_count  <= n_half_count;
            r_first_half  <= n_first_half;
            r_frame_shift <= n_frame_shift;
        end
    end

    // Hold results in the output register and the skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_pop) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= in_accept;
            end else begin
                r_out_valid  <= in_accept;
            end
        end else if (in_accept) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid  <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_pop) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
                if (in_accept) begin
                    r_skid <= n_result;
                end
            end else if (in_accept) begin
                r_out <= n_result;
            end
        end else if (in_accept) begin
            if (r_out_valid) begin
                r_skid <= n_result;
            end else begin
                r_out <= n_result;
            end
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.frame_valid = r_out.frame_valid;
    assign o_result.card_number = r_out.card_number;
    assign o_result.raw_frame   = r_out.raw_frame;
    assign o_result.sync_seen   = r_out.sync_seen;

    // The skid entry is only ever filled behind a waiting result
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid without output result");

    // A result shown with sync carries a cleared frame
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.sync_seen) |-> (o_result.raw_frame == '0))
        else $error("sync result with non-empty frame");

    // An edge taken into an empty buffer shows its result next cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !r_out_valid) |=> r_out_valid)
        else $error("accepted edge produced no result");

    // Card number is always the slice of the raw frame
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.card_number == o_result.raw_frame[CARD_WIDTH:1]))
        else $error("card number does not match raw frame");

endmodule
